### hdl/ssns_pkg.sv
// shared types, constants and the font table of the seven-segment number scanner
// no dependencies; used by every module of the block
package ssns_pkg;

    localparam int DIGIT_SLOTS = 8;
    localparam int POS_W       = 3;
    localparam int NDIG_W      = 4;
    localparam int NUM_W       = 27;
    localparam int CODE_W      = 8;
    localparam int SEG_W       = 8;
    localparam int BCD_W       = 4;

    // divide by ten as multiply by ceil(2^30 / 10), exact for every 27-bit value
    localparam int          DIV10_SHIFT = 30;
    localparam logic [26:0] DIV10_MUL   = 27'd107374183;
    localparam int          PROD_W      = 2 * NUM_W;

    // configuration register indexes
    localparam logic CFG_NUM_DIGITS   = 1'b0;
    localparam logic CFG_COMMON_ANODE = 1'b1;

    // request operations
    localparam logic OP_NUMBER = 1'b0;
    localparam logic OP_CHAR   = 1'b1;

    localparam logic [NDIG_W-1:0] NUM_DIGITS_RST = 4'd4;

    typedef struct packed {
        logic              operation;
        logic [NUM_W-1:0]  number;
        logic [CODE_W-1:0] char_code;
        logic [POS_W-1:0]  position;
    } t_in_item;

    typedef struct packed {
        logic [SEG_W-1:0]       segment_lines;
        logic [DIGIT_SLOTS-1:0] digit_lines;
        logic                   lit_phase;
        logic                   last;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic             load;
        logic             split;
        logic [POS_W-1:0] pos;
        logic             lit_phase;
        logic             last;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [NDIG_W-1:0] fitted;
    } t_dp_stat;

    // bit6 A down to bit0 G
    localparam logic [6:0] FONT_ROM [128] = '{
        7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70,
        7'h7F, 7'h7B, 7'h77, 7'h1F, 7'h4E, 7'h3D, 7'h4F, 7'h47,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h22, 7'h00, 7'h00, 7'h00, 7'h00, 7'h20,
        7'h4E, 7'h78, 7'h00, 7'h00, 7'h04, 7'h01, 7'h00, 7'h00,
        7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70,
        7'h7F, 7'h7B, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h77, 7'h1F, 7'h4E, 7'h3D, 7'h4F, 7'h47, 7'h5E,
        7'h37, 7'h30, 7'h38, 7'h00, 7'h0E, 7'h00, 7'h15, 7'h7E,
        7'h67, 7'h73, 7'h05, 7'h5B, 7'h0F, 7'h3E, 7'h00, 7'h00,
        7'h00, 7'h3B, 7'h00, 7'h4E, 7'h00, 7'h78, 7'h00, 7'h08,
        7'h02, 7'h77, 7'h1F, 7'h0D, 7'h3D, 7'h6F, 7'h47, 7'h5E,
        7'h17, 7'h10, 7'h38, 7'h00, 7'h30, 7'h00, 7'h15, 7'h1D,
        7'h67, 7'h73, 7'h05, 7'h5B, 7'h0F, 7'h3E, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    // codes past the font show a blank, the point is never lit
    function automatic logic [SEG_W-1:0] glyph(input logic [CODE_W-1:0] code);
        glyph = code[7] ? '0 : {1'b0, FONT_ROM[code[6:0]]};
    endfunction

endpackage

### hdl/ssns_ctrl.sv
// scan sequencer: accepts a request, steps the digit split of a number, then walks lit/blank results
// depends on ssns_pkg
module ssns_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_operation,
    input  logic [ssns_pkg::POS_W-1:0] i_position,
    input  ssns_pkg::t_dp_stat  i_stat,
    output ssns_pkg::t_dp_cmd   o_cmd,
    output logic                o_out_valid,
    input  logic                i_out_ready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_LIT,
        ST_BLANK
    } t_state;

    t_state                       r_state, n_state;
    logic [ssns_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [ssns_pkg::POS_W-1:0]   r_last_pos, n_last_pos;
    logic [ssns_pkg::POS_W-1:0]   w_top;
    logic                         w_accept;
    logic                         w_out_take;
    logic                         w_at_last;

    assign w_top      = ssns_pkg::POS_W'(i_stat.fitted - 4'd1);
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == ST_LIT) || (r_state == ST_BLANK);
    assign w_out_take = o_out_valid && i_out_ready;
    assign w_at_last  = (r_pos == r_last_pos);

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_last_pos = r_last_pos;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_stat.fitted != '0)) begin
                    if (i_operation == ssns_pkg::OP_CHAR) begin
                        if ({1'b0, i_position} < i_stat.fitted) begin
                            n_pos      = i_position;
                            n_last_pos = i_position;
                            n_state    = ST_LIT;
                        end
                    end else begin
                        // least significant digit lands on the rightmost position
                        n_pos   = w_top;
                        n_state = ST_SPLIT;
                    end
                end
            end
            ST_SPLIT: begin
                if (r_pos == '0) begin
                    n_last_pos = w_top;
                    n_state    = ST_LIT;
                end else begin
                    n_pos = r_pos - 1'b1;
                end
            end
            ST_LIT: begin
                if (w_out_take) begin
                    n_state = ST_BLANK;
                end
            end
            ST_BLANK: begin
                if (w_out_take) begin
                    if (w_at_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_pos   = r_pos + 1'b1;
                        n_state = ST_LIT;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pos      <= '0;
            r_last_pos <= '0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_last_pos <= n_last_pos;
        end
    end

    always_comb begin
        o_cmd.load      = w_accept;
        o_cmd.split     = (r_state == ST_SPLIT);
        o_cmd.pos       = r_pos;
        o_cmd.lit_phase = (r_state == ST_LIT);
        o_cmd.last      = (r_state == ST_BLANK) && w_at_last;
    end

endmodule

### hdl/ssns_dp.sv
// datapath: config registers, request capture, divide-by-ten digit split, drive levels
// depends on ssns_pkg
module ssns_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_index,
    input  logic [ssns_pkg::NDIG_W-1:0] i_cfg_data,
    input  ssns_pkg::t_in_item  i_in_item,
    input  ssns_pkg::t_dp_cmd   i_cmd,
    output ssns_pkg::t_dp_stat  o_stat,
    output ssns_pkg::t_out_item o_out_item
);

    logic [ssns_pkg::NDIG_W-1:0]  r_num_digits;
    logic                         r_common_anode;
    logic                         r_op;
    logic [ssns_pkg::NUM_W-1:0]   r_value;
    logic [ssns_pkg::CODE_W-1:0]  r_code;
    logic [ssns_pkg::BCD_W-1:0]   r_digits [ssns_pkg::DIGIT_SLOTS];

    logic [ssns_pkg::PROD_W-1:0]  w_prod;
    logic [ssns_pkg::NUM_W-1:0]   w_quot;
    logic [ssns_pkg::NUM_W-1:0]   w_quot10;
    logic [ssns_pkg::BCD_W-1:0]   w_rem;
    logic [ssns_pkg::CODE_W-1:0]  w_code;
    logic [ssns_pkg::SEG_W-1:0]   w_pattern;
    logic [ssns_pkg::DIGIT_SLOTS-1:0] w_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_digits   <= ssns_pkg::NUM_DIGITS_RST;
            r_common_anode <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ssns_pkg::CFG_NUM_DIGITS:   r_num_digits   <= i_cfg_data;
                ssns_pkg::CFG_COMMON_ANODE: r_common_anode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_stat.fitted = (r_num_digits > ssns_pkg::NDIG_W'(ssns_pkg::DIGIT_SLOTS))
                         ? ssns_pkg::NDIG_W'(ssns_pkg::DIGIT_SLOTS) : r_num_digits;

    // one decimal digit per cycle: quotient by reciprocal multiply, remainder by subtract
    assign w_prod   = ssns_pkg::PROD_W'(r_value) * ssns_pkg::PROD_W'(ssns_pkg::DIV10_MUL);
    assign w_quot   = ssns_pkg::NUM_W'(w_prod >> ssns_pkg::DIV10_SHIFT);
    assign w_quot10 = (w_quot << 3) + (w_quot << 1);
    assign w_rem    = ssns_pkg::BCD_W'(r_value - w_quot10);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_in_item.operation;
            r_value <= i_in_item.number;
            r_code  <= i_in_item.char_code;
        end else if (i_cmd.split) begin
            r_value              <= w_quot;
            r_digits[i_cmd.pos]  <= w_rem;
        end
    end

    assign w_code    = (r_op == ssns_pkg::OP_CHAR) ? r_code
                                                   : ssns_pkg::CODE_W'(r_digits[i_cmd.pos]);
    assign w_pattern = ssns_pkg::glyph(w_code);
    assign w_sel     = ssns_pkg::DIGIT_SLOTS'(1) << i_cmd.pos;

    always_comb begin
        o_out_item.segment_lines = r_common_anode ? ~w_pattern : w_pattern;
        if (i_cmd.lit_phase) begin
            o_out_item.digit_lines = r_common_anode ? w_sel : ~w_sel;
        end else begin
            o_out_item.digit_lines = r_common_anode ? '0 : '1;
        end
        o_out_item.lit_phase = i_cmd.lit_phase;
        o_out_item.last      = i_cmd.last;
    end

endmodule

### hdl/seven_segment_number_scanner_core.sv
// top level of the seven-segment number scanner: controller plus datapath
// depends on ssns_pkg, ssns_ctrl, ssns_dp
//
//   channel | direction | handshake                    | payload
//   --------+-----------+------------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_ready      | i_in_item  (t_in_item)
//   out     | output    | o_out_valid / i_out_ready    | o_out_item (t_out_item)
//   cfg     | input     | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// a number request is split into its n fitted digits (one divide by ten per cycle in the
// datapath), then gives 2n results, a lit and a blank drive per digit; a single
// character gives one lit and one blank drive; a dropped request gives no result
// reset (synchronous) sets 4 digits, common cathode, sequencer idle
// a stalled output holds its result; no request is taken until the last result leaves
module seven_segment_number_scanner_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ssns_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ssns_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [ssns_pkg::NDIG_W-1:0] i_cfg_data
);

    ssns_pkg::t_dp_cmd  w_cmd;
    ssns_pkg::t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    ssns_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_in_item.operation),
        .i_position  (i_in_item.position),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

    ssns_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_item  (o_out_item)
    );

endmodule

### tb/sv/tb_seven_segment_number_scanner_core.sv
// testbench of seven_segment_number_scanner_core: directed and random scan requests,
// every drive checked against a local prediction of the digit split and font lookup
// depends on ssns_pkg and the core
`timescale 1ns / 1ps

module tb_seven_segment_number_scanner_core;

    // the sequencer is idle right after its last drive, this is margin only
    localparam int DRAIN_CYCLES = 32;
    localparam int TIMEOUT_NS   = 4_000_000;

    // bit6 A down to bit0 G
    localparam logic [6:0] SEG_FONT [128] = '{
        7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70,
        7'h7F, 7'h7B, 7'h77, 7'h1F, 7'h4E, 7'h3D, 7'h4F, 7'h47,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h22, 7'h00, 7'h00, 7'h00, 7'h00, 7'h20,
        7'h4E, 7'h78, 7'h00, 7'h00, 7'h04, 7'h01, 7'h00, 7'h00,
        7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70,
        7'h7F, 7'h7B, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h77, 7'h1F, 7'h4E, 7'h3D, 7'h4F, 7'h47, 7'h5E,
        7'h37, 7'h30, 7'h38, 7'h00, 7'h0E, 7'h00, 7'h15, 7'h7E,
        7'h67, 7'h73, 7'h05, 7'h5B, 7'h0F, 7'h3E, 7'h00, 7'h00,
        7'h00, 7'h3B, 7'h00, 7'h4E, 7'h00, 7'h78, 7'h00, 7'h08,
        7'h02, 7'h77, 7'h1F, 7'h0D, 7'h3D, 7'h6F, 7'h47, 7'h5E,
        7'h17, 7'h10, 7'h38, 7'h00, 7'h30, 7'h00, 7'h15, 7'h1D,
        7'h67, 7'h73, 7'h05, 7'h5B, 7'h0F, 7'h3E, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    ssns_pkg::t_in_item          i_in_item;
    logic                        o_out_valid;
    logic                        i_out_ready;
    ssns_pkg::t_out_item         o_out_item;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic                        i_cfg_index;
    logic [ssns_pkg::NDIG_W-1:0] i_cfg_data;

    // local copy of the display settings
    logic [ssns_pkg::NDIG_W-1:0] cfg_digits;
    logic                        cfg_anode;

    ssns_pkg::t_out_item pending_drives [$];
    int                  mismatches;
    int                  drive_count;

    bit calm;
    int gap_pct;
    int stall_pct;
    int stall_left;

    seven_segment_number_scanner_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    function automatic logic [ssns_pkg::SEG_W-1:0] font_of(
        input logic [ssns_pkg::CODE_W-1:0] code);
        font_of = code[7] ? '0 : {1'b0, SEG_FONT[code[6:0]]};
    endfunction

    // lit drive then blanking drive for one digit position
    task automatic push_digit(input int pos, input logic [ssns_pkg::SEG_W-1:0] pattern,
                              input bit fin);
        ssns_pkg::t_out_item              lit;
        ssns_pkg::t_out_item              dark;
        logic [ssns_pkg::SEG_W-1:0]       seg;
        logic [ssns_pkg::DIGIT_SLOTS-1:0] sel;
        seg = cfg_anode ? ~pattern : pattern;
        sel = 8'b1 << pos;
        lit.segment_lines  = seg;
        lit.digit_lines    = cfg_anode ? sel : ~sel;
        lit.lit_phase      = 1'b1;
        lit.last           = 1'b0;
        dark.segment_lines = seg;
        dark.digit_lines   = cfg_anode ? 8'h00 : 8'hFF;
        dark.lit_phase     = 1'b0;
        dark.last          = fin;
        pending_drives.push_back(lit);
        pending_drives.push_back(dark);
    endtask

    task automatic predict_scan(input ssns_pkg::t_in_item req);
        int                         n;
        int                         i;
        logic [ssns_pkg::NUM_W-1:0] v;
        logic [3:0]                 dig [ssns_pkg::DIGIT_SLOTS];
        n = (cfg_digits > ssns_pkg::DIGIT_SLOTS) ? ssns_pkg::DIGIT_SLOTS : int'(cfg_digits);
        if (n == 0) return;
        if (req.operation == ssns_pkg::OP_CHAR) begin
            if (int'(req.position) >= n) return;
            push_digit(int'(req.position), font_of(req.char_code), 1'b1);
        end else begin
            v = req.number;
            for (i = n - 1; i >= 0; i--) begin
                dig[i] = 4'(v % 10);
                v      = ssns_pkg::NUM_W'(v / 10);
            end
            for (i = 0; i < n; i++)
                push_digit(i, font_of({4'b0, dig[i]}), i == n - 1);
        end
    endtask

    function automatic ssns_pkg::t_in_item make_request(input logic op, input int number,
                                                        input int code, input int pos);
        ssns_pkg::t_in_item req;
        req.operation = op;
        req.number    = ssns_pkg::NUM_W'(number);
        req.char_code = ssns_pkg::CODE_W'(code);
        req.position  = ssns_pkg::POS_W'(pos);
        return req;
    endfunction

    task automatic send_request(input ssns_pkg::t_in_item req);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        predict_scan(req);
    endtask

    // stop sending, let every drive come out and the sequencer go idle
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [ssns_pkg::NDIG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == ssns_pkg::CFG_NUM_DIGITS) cfg_digits = data;
        else cfg_anode = data[0];
    endtask

    task automatic configure(input logic [ssns_pkg::NDIG_W-1:0] digits,
                             input logic [ssns_pkg::NDIG_W-1:0] anode);
        settle_block();
        write_reg(ssns_pkg::CFG_NUM_DIGITS, digits);
        write_reg(ssns_pkg::CFG_COMMON_ANODE, anode);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count);
        ssns_pkg::t_in_item req;
        int                 n;
        int                 k;
        int                 pick;
        n = (cfg_digits > ssns_pkg::DIGIT_SLOTS) ? ssns_pkg::DIGIT_SLOTS : int'(cfg_digits);
        for (k = 0; k < count; k++) begin
            req.operation = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 9);
            if (pick < 4) req.number = ssns_pkg::NUM_W'($urandom_range(0, 99999999));
            else if (pick < 6) req.number = ssns_pkg::NUM_W'($urandom_range(0, 999));
            else if (pick == 6)
                req.number = 27'h7FFFFFF - ssns_pkg::NUM_W'($urandom_range(0, 15));
            else req.number = ssns_pkg::NUM_W'($urandom());
            req.char_code = ($urandom_range(0, 9) < 7)
                          ? ssns_pkg::CODE_W'($urandom_range(0, 127))
                          : ssns_pkg::CODE_W'($urandom_range(128, 255));
            if (n > 0 && $urandom_range(0, 4) != 0)
                req.position = ssns_pkg::POS_W'($urandom_range(0, n - 1));
            else req.position = ssns_pkg::POS_W'($urandom_range(0, 7));
            send_request(req);
        end
    endtask

    task automatic test_reset_defaults();
        send_request(make_request(ssns_pkg::OP_NUMBER, 0, 0, 0));
        send_request(make_request(ssns_pkg::OP_NUMBER, 1234, 255, 7));
        send_request(make_request(ssns_pkg::OP_NUMBER, 99999999, 0, 0));
        send_request(make_request(ssns_pkg::OP_NUMBER, 27'h7FFFFFF, 0, 0));
        send_request(make_request(ssns_pkg::OP_CHAR, 0, 0, 0));
        send_request(make_request(ssns_pkg::OP_CHAR, 0, 15, 3));
        send_request(make_request(ssns_pkg::OP_CHAR, 27'h7FFFFFF, 72, 1));
        send_request(make_request(ssns_pkg::OP_CHAR, 0, 128, 2));
        send_request(make_request(ssns_pkg::OP_CHAR, 0, 255, 0));
        // positions past the fitted count are dropped
        send_request(make_request(ssns_pkg::OP_CHAR, 0, 8, 4));
        send_request(make_request(ssns_pkg::OP_CHAR, 0, 8, 7));
    endtask

    task automatic test_common_anode();
        // only bit 0 of the polarity data counts
        configure(4'd8, 4'hF);
        send_request(make_request(ssns_pkg::OP_NUMBER, 12345678, 0, 0));
        send_request(make_request(ssns_pkg::OP_NUMBER, 27'h7FFFFFF, 0, 0));
        send_request(make_request(ssns_pkg::OP_CHAR, 0, 127, 7));
        send_request(make_request(ssns_pkg::OP_CHAR, 0, 45, 6));
        send_request(make_request(ssns_pkg::OP_CHAR, 0, 200, 0));
    endtask

    task automatic test_digit_count_edges();
        // zero digits fitted: nothing comes out
        configure(4'd0, 4'hE);
        send_request(make_request(ssns_pkg::OP_NUMBER, 5555, 0, 0));
        send_request(make_request(ssns_pkg::OP_CHAR, 0, 1, 0));
        // counts past eight act as eight
        configure(4'd15, 4'h1);
        send_request(make_request(ssns_pkg::OP_NUMBER, 87654321, 0, 0));
        send_request(make_request(ssns_pkg::OP_CHAR, 0, 1, 7));
        configure(4'd9, 4'h0);
        send_request(make_request(ssns_pkg::OP_CHAR, 0, 2, 7));
        configure(4'd1, 4'h0);
        send_request(make_request(ssns_pkg::OP_NUMBER, 9, 0, 0));
        send_request(make_request(ssns_pkg::OP_CHAR, 0, 7, 0));
        send_request(make_request(ssns_pkg::OP_CHAR, 0, 7, 1));
    endtask

    task automatic test_random_mix();
        int                          ph;
        int                          pick;
        logic [ssns_pkg::NDIG_W-1:0] digits;
        for (ph = 0; ph < 7; ph++) begin
            pick = $urandom_range(0, 9);
            if (ph == 0) digits = 4'd8;
            else if (ph == 1) digits = 4'd1;
            else if (pick < 2) digits = ssns_pkg::NDIG_W'($urandom_range(9, 15));
            else digits = ssns_pkg::NDIG_W'($urandom_range(1, 8));
            configure(digits, ssns_pkg::NDIG_W'($urandom_range(0, 15)));
            if (ph == 2) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = $urandom_range(10, 50);
                stall_pct = $urandom_range(5, 40);
            end
            if (ph == 3) begin
                run_random(20);
                // hold off until the block has emptied
                settle_block();
                run_random(20);
            end else begin
                run_random(40);
            end
        end
    endtask

    task automatic test_calm_tail();
        calm = 1'b1;
        configure(ssns_pkg::NDIG_W'($urandom_range(1, 8)),
                  ssns_pkg::NDIG_W'($urandom_range(0, 15)));
        run_random(40);
    endtask

    always @(posedge i_clk) begin : drive_ready
        if (!calm && stall_left == 0 && $urandom_range(0, 99) < stall_pct)
            stall_left = $urandom_range(1, 8);
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_drives
        ssns_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_drives.size() == 0) begin
                $display("%0t unexpected drive: expected none, actual %h", $time, o_out_item);
                mismatches++;
            end else begin
                want = pending_drives.pop_front();
                if (o_out_item.segment_lines !== want.segment_lines) begin
                    $display("%0t drive %0d segment_lines: expected %h, actual %h", $time,
                             drive_count, want.segment_lines, o_out_item.segment_lines);
                    mismatches++;
                end
                if (o_out_item.digit_lines !== want.digit_lines) begin
                    $display("%0t drive %0d digit_lines: expected %h, actual %h", $time,
                             drive_count, want.digit_lines, o_out_item.digit_lines);
                    mismatches++;
                end
                if (o_out_item.lit_phase !== want.lit_phase) begin
                    $display("%0t drive %0d lit_phase: expected %b, actual %b", $time,
                             drive_count, want.lit_phase, o_out_item.lit_phase);
                    mismatches++;
                end
                if (o_out_item.last !== want.last) begin
                    $display("%0t drive %0d last: expected %b, actual %b", $time,
                             drive_count, want.last, o_out_item.last);
                    mismatches++;
                end
            end
            drive_count++;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = ssns_pkg::CFG_NUM_DIGITS;
        i_cfg_data  = '0;
        cfg_digits  = ssns_pkg::NUM_DIGITS_RST;
        cfg_anode   = 1'b0;
        mismatches  = 0;
        drive_count = 0;
        calm        = 1'b0;
        gap_pct     = 25;
        stall_pct   = 20;
        stall_left  = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_common_anode();
        test_digit_count_edges();
        test_random_mix();
        test_calm_tail();

        settle_block();
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
hdl/ssns_pkg.sv
hdl/ssns_ctrl.sv
hdl/ssns_dp.sv
hdl/seven_segment_number_scanner_core.sv
tb/sv/tb_seven_segment_number_scanner_core.sv
